// ----- hdl/prc_pkg.sv -----
`timescale 1ns / 1ps

package prc_pkg;

   // Fixed field widths of the transactions.
   localparam int FINGER_W      = 8;
   localparam int INPUT_FINGERS = 5;
   localparam int INDEX_W       = 4;
   localparam int USED_W        = 5;
   localparam int CTRL_USED_W   = 3;

   // Default table sizes and lane count.
   localparam int DEF_SPEECH_POSTURES  = 16;
   localparam int DEF_CONTROL_POSTURES = 4;
   localparam int DEF_FINGERS          = 5;

   // Reset values of the configuration registers.
   localparam logic [USED_W-1:0]      SPEECH_USED_RESET  = 5'd15;
   localparam logic [CTRL_USED_W-1:0] CONTROL_USED_RESET = 3'd3;

   // Request and response bus layout.
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;
   localparam int FINGER_LSB  = INDEX_W;

   localparam int TUSER_COMMAND_BIT = 0;
   localparam int TUSER_TABLE_BIT   = 1;
   localparam int TUSER_BOUND_BIT   = 2;

   // Configuration port layout.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = USED_W;

   typedef enum logic {
      CMD_WRITE    = 1'b0,
      CMD_CLASSIFY = 1'b1
   } command_type;

   typedef enum logic {
      TABLE_SPEECH  = 1'b0,
      TABLE_CONTROL = 1'b1
   } table_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEECH_USED  = 1'b0,
      CSR_CONTROL_USED = 1'b1
   } csr_index_type;

endpackage

// ----- hdl/posture_range_classifier.sv -----
`timescale 1ns / 1ps

// Posture range classifier. A write transaction stores one bound row of one
// posture in the speech or the control table. A classify transaction walks
// the selected table from posture 0 upward over the used postures; each
// posture takes an issue step for the bound memory read and a check step for
// the range compare over all finger lanes, and the walk stops at the first
// match or after the last used posture. The response carries the lowest
// matching posture, or no match with posture 0. The speech table has no reset
// and every speech row compared must have been written first; the control
// table reads as zero until written. A new request is taken while a finished
// response still waits on the response side.
module posture_range_classifier
   import prc_pkg::*;
#(
   parameter int SPEECH_POSTURES  = DEF_SPEECH_POSTURES,
   parameter int CONTROL_POSTURES = DEF_CONTROL_POSTURES,
   parameter int FINGERS          = DEF_FINGERS
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata from bit 0: posture_index, finger_a, finger_b, finger_c,
   // finger_d, finger_e, zero padding.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser from bit 0: command, table_sel, bound_sel.
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // Response stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata from bit 0: matched_posture, zero padding.
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // tuser from bit 0: match_found.
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ROW_W        = FINGERS * FINGER_W;
   localparam int SP_AW        = (SPEECH_POSTURES > 1) ? $clog2(SPEECH_POSTURES) : 1;
   localparam int CT_AW        = (CONTROL_POSTURES > 1) ? $clog2(CONTROL_POSTURES) : 1;
   localparam int MAX_POSTURES = (SPEECH_POSTURES > CONTROL_POSTURES) ?
                                 SPEECH_POSTURES : CONTROL_POSTURES;
   localparam int CNT_BITS     = $clog2(MAX_POSTURES + 1);
   localparam int CNT_W        = (CNT_BITS > USED_W) ? CNT_BITS : USED_W;
   localparam logic [CNT_W-1:0] SPEECH_CAP  = CNT_W'(SPEECH_POSTURES);
   localparam logic [CNT_W-1:0] CONTROL_CAP = CNT_W'(CONTROL_POSTURES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           addr_ff, addr_in;
   logic [CNT_W-1:0]           limit_ff, limit_in;
   logic                       table_ff, table_in;
   logic [ROW_W-1:0]           vals_ff, vals_in;
   logic                       found_ff, found_in;
   logic [INDEX_W-1:0]         posture_ff, posture_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_match_ff, rsp_match_in;
   logic [INDEX_W-1:0]         rsp_posture_ff, rsp_posture_in;
   logic [USED_W-1:0]          speech_used_ff;
   logic [CTRL_USED_W-1:0]     control_used_ff;

   logic                       req_accept;
   logic                       req_is_write;
   logic                       req_table;
   logic [ROW_W-1:0]           req_row;
   logic [CNT_W-1:0]           wr_idx;
   logic [CNT_W-1:0]           speech_limit;
   logic [CNT_W-1:0]           control_limit;
   logic                       sp_wr_en;
   logic                       ct_wr_en;
   logic [ROW_W-1:0]           sp_row0, sp_row1;
   logic [ROW_W-1:0]           ct_row0, ct_row1;
   logic [ROW_W-1:0]           sel_row0, sel_row1;
   logic [FINGERS-1:0]         lane_hit;
   logic                       posture_hit;

   // Unpack the finger lanes; lanes beyond the five inputs carry zero.
   genvar j;
   generate
      for (j = 0; j < FINGERS; j++) begin : g_row
         if (j < INPUT_FINGERS) begin : g_field
            assign req_row[j*FINGER_W +: FINGER_W] =
               req_tdata[FINGER_LSB + j*FINGER_W +: FINGER_W];
         end else begin : g_zero
            assign req_row[j*FINGER_W +: FINGER_W] = '0;
         end
      end
   endgenerate

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_is_write = (req_tuser[TUSER_COMMAND_BIT] == CMD_WRITE);
   assign req_table    = req_tuser[TUSER_TABLE_BIT];
   assign wr_idx       = CNT_W'(req_tdata[INDEX_W-1:0]);

   // Used counts saturate at the table sizes.
   assign speech_limit  = (CNT_W'(speech_used_ff) > SPEECH_CAP) ?
                          SPEECH_CAP : CNT_W'(speech_used_ff);
   assign control_limit = (CNT_W'(control_used_ff) > CONTROL_CAP) ?
                          CONTROL_CAP : CNT_W'(control_used_ff);

   // Writes beyond the table size are dropped.
   assign sp_wr_en = req_accept && req_is_write && (req_table == TABLE_SPEECH) &&
                     (wr_idx < SPEECH_CAP);
   assign ct_wr_en = req_accept && req_is_write && (req_table == TABLE_CONTROL) &&
                     (wr_idx < CONTROL_CAP);

   prc_bound_mem #(
      .DEPTH     (SPEECH_POSTURES),
      .LANES     (FINGERS),
      .HAS_VALID (1'b0)
   ) u_speech_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (sp_wr_en),
      .wr_bound (req_tuser[TUSER_BOUND_BIT]),
      .wr_addr  (wr_idx[SP_AW-1:0]),
      .wr_row   (req_row),
      .rd_addr  (addr_ff[SP_AW-1:0]),
      .rd_row0  (sp_row0),
      .rd_row1  (sp_row1)
   );

   prc_bound_mem #(
      .DEPTH     (CONTROL_POSTURES),
      .LANES     (FINGERS),
      .HAS_VALID (1'b1)
   ) u_control_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (ct_wr_en),
      .wr_bound (req_tuser[TUSER_BOUND_BIT]),
      .wr_addr  (wr_idx[CT_AW-1:0]),
      .wr_row   (req_row),
      .rd_addr  (addr_ff[CT_AW-1:0]),
      .rd_row0  (ct_row0),
      .rd_row1  (ct_row1)
   );

   assign sel_row0 = (table_ff == TABLE_CONTROL) ? ct_row0 : sp_row0;
   assign sel_row1 = (table_ff == TABLE_CONTROL) ? ct_row1 : sp_row1;

   // One compare lane per finger.
   generate
      for (j = 0; j < FINGERS; j++) begin : g_lane
         prc_lane u_lane (
            .value  (vals_ff[j*FINGER_W +: FINGER_W]),
            .bound0 (sel_row0[j*FINGER_W +: FINGER_W]),
            .bound1 (sel_row1[j*FINGER_W +: FINGER_W]),
            .hit    (lane_hit[j])
         );
      end
   endgenerate

   // Merge the lanes: a posture matches only when every finger is in range.
   assign posture_hit = &lane_hit;

   // Sequencer next state.
   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      limit_in       = limit_ff;
      table_in       = table_ff;
      vals_in        = vals_ff;
      found_in       = found_ff;
      posture_in     = posture_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_match_in   = rsp_match_ff;
      rsp_posture_in = rsp_posture_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !req_is_write) begin
               table_in   = req_table;
               vals_in    = req_row;
               addr_in    = '0;
               found_in   = 1'b0;
               posture_in = '0;
               limit_in   = (req_table == TABLE_CONTROL) ? control_limit : speech_limit;
               if (((req_table == TABLE_CONTROL) ? control_limit : speech_limit) == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (posture_hit) begin
               found_in   = 1'b1;
               posture_in = addr_ff[INDEX_W-1:0];
               state_in   = ST_FINISH;
            end else if (addr_ff + 1'b1 == limit_ff) begin
               state_in = ST_FINISH;
            end else begin
               addr_in  = addr_ff + 1'b1;
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_match_in   = found_ff;
               rsp_posture_in = posture_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      limit_ff       <= limit_in;
      table_ff       <= table_in;
      vals_ff        <= vals_in;
      found_ff       <= found_in;
      posture_ff     <= posture_in;
      rsp_match_ff   <= rsp_match_in;
      rsp_posture_ff <= rsp_posture_in;
   end

   // Configuration registers; the port is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speech_used_ff  <= SPEECH_USED_RESET;
         control_used_ff <= CONTROL_USED_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEECH_USED:  speech_used_ff  <= csr_data;
            CSR_CONTROL_USED: control_used_ff <= csr_data[CTRL_USED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_posture_ff);
   assign rsp_tuser  = RSP_TUSER_W'(rsp_match_ff);

   // A classify transaction holds off further requests in the cycle after it is accepted.
   a_classify_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_is_write) |=> !req_tready)
      else $error("request accepted during a classify");

   // The scan address never reaches the used count.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE || state_ff == ST_CHECK) |-> (addr_ff < limit_ff))
      else $error("scan address beyond used postures");

   // A new response comes only out of the finish step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the finish step");

   // A miss always reports posture zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_match_ff) |-> (rsp_posture_ff == '0))
      else $error("no-match response with non-zero posture");

endmodule

// ----- hdl/prc_lane.sv -----
`timescale 1ns / 1ps

// One finger lane: checks a value against two bounds held in either order.
module prc_lane
   import prc_pkg::*;
(
   input  logic [FINGER_W-1:0] value,
   input  logic [FINGER_W-1:0] bound0,
   input  logic [FINGER_W-1:0] bound1,
   output logic                hit
);

   logic [FINGER_W-1:0] lo;
   logic [FINGER_W-1:0] hi;

   // Order the bounds, then test inclusively.
   always_comb begin
      if (bound0 < bound1) begin
         lo = bound0;
         hi = bound1;
      end else begin
         lo = bound1;
         hi = bound0;
      end
      hit = (value >= lo) && (value <= hi);
   end

endmodule

// ----- hdl/prc_bound_mem.sv -----
`timescale 1ns / 1ps

// Bound store for one posture table: two row memories, one per bound, read
// together at one address with registered read data.
module prc_bound_mem
   import prc_pkg::*;
#(
   parameter int DEPTH     = DEF_CONTROL_POSTURES,
   parameter int LANES     = DEF_FINGERS,
   parameter bit HAS_VALID = 1'b0,
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int ROW_W    = LANES * FINGER_W
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic             wr_bound,
   input  logic [AW-1:0]    wr_addr,
   input  logic [ROW_W-1:0] wr_row,
   input  logic [AW-1:0]    rd_addr,
   output logic [ROW_W-1:0] rd_row0,
   output logic [ROW_W-1:0] rd_row1
);

   logic [ROW_W-1:0] row0_mem_ff [DEPTH];
   logic [ROW_W-1:0] row1_mem_ff [DEPTH];
   logic [ROW_W-1:0] rd0_ff;
   logic [ROW_W-1:0] rd1_ff;

   // Write one bound row and read both rows of the addressed posture.
   always_ff @(posedge clock) begin
      if (wr_en && !wr_bound) begin
         row0_mem_ff[wr_addr] <= wr_row;
      end
      if (wr_en && wr_bound) begin
         row1_mem_ff[wr_addr] <= wr_row;
      end
      rd0_ff <= row0_mem_ff[rd_addr];
      rd1_ff <= row1_mem_ff[rd_addr];
   end

   generate
      if (HAS_VALID) begin : g_valid
         logic [DEPTH-1:0] valid0_ff;
         logic [DEPTH-1:0] valid1_ff;
         logic             rdv0_ff;
         logic             rdv1_ff;

         // Valid bits make a row that was never written read as zero.
         always_ff @(posedge clock) begin
            if (reset) begin
               valid0_ff <= '0;
               valid1_ff <= '0;
               rdv0_ff   <= 1'b0;
               rdv1_ff   <= 1'b0;
            end else begin
               if (wr_en && !wr_bound) begin
                  valid0_ff[wr_addr] <= 1'b1;
               end
               if (wr_en && wr_bound) begin
                  valid1_ff[wr_addr] <= 1'b1;
               end
               rdv0_ff <= valid0_ff[rd_addr];
               rdv1_ff <= valid1_ff[rd_addr];
            end
         end

         assign rd_row0 = rdv0_ff ? rd0_ff : '0;
         assign rd_row1 = rdv1_ff ? rd1_ff : '0;
      end else begin : g_plain
         assign rd_row0 = rd0_ff;
         assign rd_row1 = rd1_ff;
      end
   endgenerate

endmodule
